@@ design/crge_pkg.sv @@
// Package with shared types, codes and constants of the color region grow engine.
`timescale 1ns / 1ps
package crge_pkg;

   localparam int MAX_ROWS   = 256;
   localparam int MAX_COLS   = 256;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int CELLS      = MAX_ROWS * MAX_COLS;
   localparam int DEPTH_W    = ADDR_W + 1;
   localparam int SIZE_W     = 9;
   localparam int THR_W      = 9;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int SQ_W       = 2 * CHAN_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int LIM_W      = 2 * (THR_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_GROW  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_ROW   = 3'd0,
      CSR_SEED_COL   = 3'd1,
      CSR_THRESHOLD  = 3'd2,
      CSR_IMAGE_ROWS = 3'd3,
      CSR_IMAGE_COLS = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR_BOOT,
      ST_CLEAR_OP,
      ST_IDLE,
      ST_READ_ISSUE,
      ST_READ_WAIT,
      ST_GROW_SEED,
      ST_GROW_REF,
      ST_SCAN_ISSUE,
      ST_SCAN_DATA,
      ST_SCAN_TEST,
      ST_POP,
      ST_POP_WAIT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic clr_start;
      logic clr_step;
      logic load_wr;
      logic req_capture;
      logic rd_issue;
      logic rsp_read;
      logic rsp_zero;
      logic seed_issue;
      logic ref_capture;
      logic center_from_req;
      logic center_from_stack;
      logic nb_reset;
      logic nb_next;
      logic nb_issue;
      logic sq_capture;
      logic mark;
      logic pop_issue;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic nb_inside;
      logic nb_last;
      logic nb_join;
      logic depth_zero;
   } status_type;

endpackage

@@ design/crge_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module crge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/crge_ctrl.sv @@
// Controller state machine sequencing loads, reads, mask clears and the flood fill.
`timescale 1ns / 1ps
module crge_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output crge_pkg::cmd_type    cmd,
   input  crge_pkg::status_type status
);
   import crge_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR_BOOT: begin
            cmd.clr_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR_OP: begin
            cmd.clr_step = 1'b1;
            if (status.sweep_last) begin
               cmd.rsp_zero = 1'b1;
               state_in     = ST_RESPOND;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_capture = 1'b1;
               unique case (op_type'(req_operation))
                  OP_LOAD: begin
                     cmd.load_wr  = 1'b1;
                     cmd.rsp_zero = 1'b1;
                     state_in     = ST_RESPOND;
                  end
                  OP_GROW:  state_in = ST_GROW_SEED;
                  OP_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     state_in      = ST_CLEAR_OP;
                  end
                  OP_READ:  state_in = ST_READ_ISSUE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            cmd.rsp_read = 1'b1;
            state_in     = ST_RESPOND;
         end
         ST_GROW_SEED: begin
            cmd.seed_issue = 1'b1;
            state_in       = ST_GROW_REF;
         end
         ST_GROW_REF: begin
            cmd.ref_capture     = 1'b1;
            cmd.center_from_req = 1'b1;
            cmd.nb_reset        = 1'b1;
            state_in            = ST_SCAN_ISSUE;
         end
         ST_SCAN_ISSUE: begin
            if (status.nb_inside) begin
               cmd.nb_issue = 1'b1;
               state_in     = ST_SCAN_DATA;
            end else if (status.nb_last) begin
               state_in = ST_POP;
            end else begin
               cmd.nb_next = 1'b1;
            end
         end
         ST_SCAN_DATA: begin
            cmd.sq_capture = 1'b1;
            state_in       = ST_SCAN_TEST;
         end
         ST_SCAN_TEST: begin
            cmd.mark = status.nb_join;
            if (status.nb_last) begin
               state_in = ST_POP;
            end else begin
               cmd.nb_next = 1'b1;
               state_in    = ST_SCAN_ISSUE;
            end
         end
         ST_POP: begin
            if (status.depth_zero) begin
               cmd.rsp_zero = 1'b1;
               state_in     = ST_RESPOND;
            end else begin
               cmd.pop_issue = 1'b1;
               state_in      = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cmd.center_from_stack = 1'b1;
            cmd.nb_reset          = 1'b1;
            state_in              = ST_SCAN_ISSUE;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

@@ design/crge_datapath.sv @@
// Datapath with image, mask and stack memories, neighbor walk and color test.
`timescale 1ns / 1ps
module crge_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [crge_pkg::ROW_W-1:0]       req_row,
   input  logic [crge_pkg::COL_W-1:0]       req_col,
   input  logic [crge_pkg::CHAN_W-1:0]      req_blue_in,
   input  logic [crge_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [crge_pkg::CHAN_W-1:0]      req_red_in,
   input  logic                             csr_wr_en,
   input  logic [crge_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [crge_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [crge_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic [crge_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [crge_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic                             rsp_marked,
   input  crge_pkg::cmd_type                cmd,
   output crge_pkg::status_type             status
);
   import crge_pkg::*;

   logic [ROW_W-1:0]   seed_row_ff;
   logic [COL_W-1:0]   seed_col_ff;
   logic [THR_W-1:0]   threshold_ff;
   logic [SIZE_W-1:0]  image_rows_ff;
   logic [SIZE_W-1:0]  image_cols_ff;
   logic [SIZE_W-1:0]  used_rows;
   logic [SIZE_W-1:0]  used_cols;

   logic [ROW_W-1:0]   req_row_ff;
   logic [COL_W-1:0]   req_col_ff;
   logic [ROW_W-1:0]   center_row_ff;
   logic [COL_W-1:0]   center_col_ff;
   logic [1:0]         dr_ff, dr_in;
   logic [1:0]         dc_ff, dc_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [PIX_W-1:0]   ref_ff;
   logic [LIM_W-1:0]   limit_ff;
   logic [SQ_W-1:0]    sq_ff [3];
   logic [CHAN_W-1:0]  rsp_blue_ff, rsp_green_ff, rsp_red_ff;
   logic               rsp_marked_ff;

   logic [SIZE_W:0]    nb_y, nb_x;
   logic [ADDR_W-1:0]  nb_addr, req_addr, seed_addr;
   logic [THR_W:0]     thr_plus;
   logic [SUM_W-1:0]   sum;
   logic               read_inside;

   logic               img_wr_en, img_rd_en;
   logic [ADDR_W-1:0]  img_rd_addr;
   logic [PIX_W-1:0]   img_rd_data;
   logic               msk_wr_en, msk_rd_en, msk_wr_data;
   logic [ADDR_W-1:0]  msk_wr_addr, msk_rd_addr;
   logic               msk_rd_data;
   logic [ADDR_W-1:0]  stk_rd_data;

   assign used_rows = (image_rows_ff > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : image_rows_ff;
   assign used_cols = (image_cols_ff > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : image_cols_ff;

   assign nb_y = (SIZE_W+1)'(center_row_ff) + (SIZE_W+1)'(dr_ff) - (SIZE_W+1)'(1);
   assign nb_x = (SIZE_W+1)'(center_col_ff) + (SIZE_W+1)'(dc_ff) - (SIZE_W+1)'(1);
   assign nb_addr   = {nb_y[ROW_W-1:0], nb_x[COL_W-1:0]};
   assign req_addr  = {req_row_ff, req_col_ff};
   assign seed_addr = {seed_row_ff, seed_col_ff};
   assign thr_plus  = (THR_W+1)'(threshold_ff) + (THR_W+1)'(1);
   assign sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   assign read_inside = ((SIZE_W)'(req_row_ff) < used_rows) && ((SIZE_W)'(req_col_ff) < used_cols);

   assign status.sweep_last = (sweep_ff == {ADDR_W{1'b1}});
   assign status.nb_inside  = !nb_y[SIZE_W] && !nb_x[SIZE_W]
                              && (nb_y[SIZE_W-1:0] < used_rows) && (nb_x[SIZE_W-1:0] < used_cols);
   assign status.nb_last    = (dr_ff == 2'd2) && (dc_ff == 2'd2);
   assign status.nb_join    = !msk_rd_data && (LIM_W'(sum) < limit_ff);
   assign status.depth_zero = (depth_ff == '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_row_ff   <= '0;
         seed_col_ff   <= '0;
         threshold_ff  <= '0;
         image_rows_ff <= SIZE_W'(MAX_ROWS);
         image_cols_ff <= SIZE_W'(MAX_COLS);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEED_ROW:   seed_row_ff   <= csr_wdata[ROW_W-1:0];
            CSR_SEED_COL:   seed_col_ff   <= csr_wdata[COL_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[THR_W-1:0];
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_COLS: image_cols_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.clr_start) begin
         sweep_in = '0;
      end else if (cmd.clr_step) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
      dr_in = dr_ff;
      dc_in = dc_ff;
      if (cmd.nb_reset) begin
         dr_in = '0;
         dc_in = '0;
      end else if (cmd.nb_next) begin
         if (dc_ff == 2'd2) begin
            dc_in = '0;
            dr_in = dr_ff + 2'd1;
         end else begin
            dc_in = dc_ff + 2'd1;
         end
      end
      depth_in = depth_ff;
      if (cmd.mark) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (cmd.pop_issue) begin
         depth_in = depth_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         depth_ff <= '0;
         dr_ff    <= '0;
         dc_ff    <= '0;
      end else begin
         sweep_ff <= sweep_in;
         depth_ff <= depth_in;
         dr_ff    <= dr_in;
         dc_ff    <= dc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_capture) begin
         req_row_ff <= req_row;
         req_col_ff <= req_col;
      end
      if (cmd.center_from_req) begin
         center_row_ff <= req_row_ff;
         center_col_ff <= req_col_ff;
      end else if (cmd.center_from_stack) begin
         center_row_ff <= stk_rd_data[ADDR_W-1:COL_W];
         center_col_ff <= stk_rd_data[COL_W-1:0];
      end
      if (cmd.ref_capture) begin
         ref_ff   <= img_rd_data;
         limit_ff <= LIM_W'(thr_plus) * LIM_W'(thr_plus);
      end
      if (cmd.sq_capture) begin
         for (int k = 0; k < 3; k++) begin
            logic [CHAN_W-1:0] a, b, d;
            a = img_rd_data[k*CHAN_W +: CHAN_W];
            b = ref_ff[k*CHAN_W +: CHAN_W];
            d = (a > b) ? (a - b) : (b - a);
            sq_ff[k] <= SQ_W'(d) * SQ_W'(d);
         end
      end
      if (cmd.rsp_zero) begin
         rsp_blue_ff   <= '0;
         rsp_green_ff  <= '0;
         rsp_red_ff    <= '0;
         rsp_marked_ff <= 1'b0;
      end else if (cmd.rsp_read) begin
         if (read_inside && msk_rd_data) begin
            rsp_blue_ff   <= img_rd_data[0 +: CHAN_W];
            rsp_green_ff  <= img_rd_data[CHAN_W +: CHAN_W];
            rsp_red_ff    <= img_rd_data[2*CHAN_W +: CHAN_W];
            rsp_marked_ff <= 1'b1;
         end else begin
            rsp_blue_ff   <= '0;
            rsp_green_ff  <= '0;
            rsp_red_ff    <= '0;
            rsp_marked_ff <= 1'b0;
         end
      end
   end

   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_marked    = rsp_marked_ff;

   assign img_wr_en   = cmd.load_wr;
   assign img_rd_en   = cmd.rd_issue || cmd.seed_issue || cmd.nb_issue;
   assign img_rd_addr = cmd.seed_issue ? seed_addr : (cmd.nb_issue ? nb_addr : req_addr);

   crge_ram #(.WIDTH(PIX_W), .DEPTH(CELLS)) u_image (
      .clock   (clock),
      .wr_en   (img_wr_en),
      .wr_addr ({req_row, req_col}),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (img_rd_en),
      .rd_addr (img_rd_addr),
      .rd_data (img_rd_data)
   );

   assign msk_wr_en   = cmd.clr_step || cmd.mark;
   assign msk_wr_addr = cmd.mark ? nb_addr : sweep_ff;
   assign msk_wr_data = cmd.mark;
   assign msk_rd_en   = cmd.rd_issue || cmd.nb_issue;
   assign msk_rd_addr = cmd.nb_issue ? nb_addr : req_addr;

   crge_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mask (
      .clock   (clock),
      .wr_en   (msk_wr_en),
      .wr_addr (msk_wr_addr),
      .wr_data (msk_wr_data),
      .rd_en   (msk_rd_en),
      .rd_addr (msk_rd_addr),
      .rd_data (msk_rd_data)
   );

   crge_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.mark),
      .wr_addr (depth_ff[ADDR_W-1:0]),
      .wr_data (nb_addr),
      .rd_en   (cmd.pop_issue),
      .rd_addr (depth_in[ADDR_W-1:0]),
      .rd_data (stk_rd_data)
   );
endmodule

@@ design/color_region_grow_engine.sv @@
// Top level of the color region grow engine: controller plus datapath.
// Load: accepted in idle, result offered the next cycle. Read: image and mask are read, then the registered result.
// Clear: one mask entry per cycle over the whole mask, then the result.
// Grow: the seed color is read first; each scan then issues, fetches and tests every
// in-image neighbor, skips outside ones, pops the stack, and ends on an empty stack.
// Reset (synchronous): full mask clearing pass; no transaction taken until done.
`timescale 1ns / 1ps
module color_region_grow_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_operation,
   input  logic [crge_pkg::ROW_W-1:0]       req_row,
   input  logic [crge_pkg::COL_W-1:0]       req_col,
   input  logic [crge_pkg::CHAN_W-1:0]      req_blue_in,
   input  logic [crge_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [crge_pkg::CHAN_W-1:0]      req_red_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [crge_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic [crge_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [crge_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic                             rsp_marked,
   input  logic                             csr_wr_en,
   input  logic [crge_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [crge_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import crge_pkg::*;

   cmd_type    cmd;
   status_type status;

   crge_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   crge_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_marked    (rsp_marked),
      .cmd           (cmd),
      .status        (status)
   );
endmodule

@@ test/region_grow_checker.sv @@
// Checker that predicts and compares every result of the color region grow engine.
`timescale 1ns / 1ps
module region_grow_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [crge_pkg::ROW_W-1:0]      req_row,
   input  logic [crge_pkg::COL_W-1:0]      req_col,
   input  logic [crge_pkg::CHAN_W-1:0]     req_blue_in,
   input  logic [crge_pkg::CHAN_W-1:0]     req_green_in,
   input  logic [crge_pkg::CHAN_W-1:0]     req_red_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [crge_pkg::CHAN_W-1:0]     rsp_blue_out,
   input  logic [crge_pkg::CHAN_W-1:0]     rsp_green_out,
   input  logic [crge_pkg::CHAN_W-1:0]     rsp_red_out,
   input  logic                            rsp_marked,
   input  logic                            csr_wr_en,
   input  logic [crge_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crge_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              failures,
   output int                              awaiting
);
   import crge_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              marked;
   } pixel_reply_type;

   logic [PIX_W-1:0] pixels [CELLS];
   bit               region [CELLS];
   int               flood_stack [$];
   pixel_reply_type  expected_replies [$];
   logic [7:0]       seed_row_q, seed_col_q;
   logic [8:0]       threshold_q, rows_q, cols_q;

   function automatic int rows_in_use();
      return (rows_q > MAX_ROWS) ? MAX_ROWS : int'(rows_q);
   endfunction

   function automatic int cols_in_use();
      return (cols_q > MAX_COLS) ? MAX_COLS : int'(cols_q);
   endfunction

   function automatic bit color_near(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      int sum;
      int diff;
      int limit;
      sum = 0;
      limit = (int'(threshold_q) + 1) * (int'(threshold_q) + 1);
      for (int k = 0; k < 3; k++) begin
         diff = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
         sum += diff * diff;
      end
      return sum < limit;
   endfunction

   task automatic mark_around(int r, int c, logic [PIX_W-1:0] base);
      int y;
      int x;
      int a;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            y = r + dr;
            x = c + dc;
            if (y >= 0 && x >= 0 && y < rows_in_use() && x < cols_in_use()) begin
               a = y * MAX_COLS + x;
               if (!region[a] && color_near(pixels[a], base)) begin
                  region[a] = 1'b1;
                  flood_stack = {flood_stack, a};
               end
            end
         end
      end
   endtask

   task automatic flood_region(int r, int c);
      logic [PIX_W-1:0] base;
      int a;
      base = pixels[int'(seed_row_q) * MAX_COLS + int'(seed_col_q)];
      flood_stack.delete();
      mark_around(r, c, base);
      while (flood_stack.size() > 0) begin
         a = flood_stack[$];
         flood_stack.delete(flood_stack.size() - 1);
         mark_around(a / MAX_COLS, a % MAX_COLS, base);
      end
   endtask

   task automatic predict_reply();
      pixel_reply_type want;
      int a;
      want = '0;
      a = int'(req_row) * MAX_COLS + int'(req_col);
      case (op_type'(req_operation))
         OP_LOAD: pixels[a] = {req_red_in, req_green_in, req_blue_in};
         OP_GROW: flood_region(int'(req_row), int'(req_col));
         OP_CLEAR: foreach (region[i]) region[i] = 1'b0;
         OP_READ: begin
            if (int'(req_row) < rows_in_use() && int'(req_col) < cols_in_use() && region[a])
               want = {pixels[a][7:0], pixels[a][15:8], pixels[a][23:16], 1'b1};
         end
      endcase
      expected_replies = {expected_replies, want};
   endtask

   always @(posedge clock) begin : watch
      pixel_reply_type want;
      if (reset) begin
         foreach (region[i]) region[i] = 1'b0;
         expected_replies.delete();
         seed_row_q = '0;
         seed_col_q = '0;
         threshold_q = '0;
         rows_q = 9'd256;
         cols_q = 9'd256;
         failures = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_SEED_ROW:   seed_row_q = csr_wdata[7:0];
               CSR_SEED_COL:   seed_col_q = csr_wdata[7:0];
               CSR_THRESHOLD:  threshold_q = csr_wdata;
               CSR_IMAGE_ROWS: rows_q = csr_wdata;
               CSR_IMAGE_COLS: cols_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_reply();
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $error("unexpected result transaction");
               failures++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_blue_out !== want.blue) begin
                  $error("blue_out expected %0d got %0d", want.blue, rsp_blue_out);
                  failures++;
               end
               if (rsp_green_out !== want.green) begin
                  $error("green_out expected %0d got %0d", want.green, rsp_green_out);
                  failures++;
               end
               if (rsp_red_out !== want.red) begin
                  $error("red_out expected %0d got %0d", want.red, rsp_red_out);
                  failures++;
               end
               if (rsp_marked !== want.marked) begin
                  $error("marked expected %0d got %0d", want.marked, rsp_marked);
                  failures++;
               end
            end
         end
      end
      awaiting = expected_replies.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the color region grow engine testbench: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module testbench;
   import crge_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_operation = '0;
   logic [ROW_W-1:0]      req_row = '0;
   logic [COL_W-1:0]      req_col = '0;
   logic [CHAN_W-1:0]     req_blue_in = '0;
   logic [CHAN_W-1:0]     req_green_in = '0;
   logic [CHAN_W-1:0]     req_red_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAN_W-1:0]     rsp_blue_out;
   logic [CHAN_W-1:0]     rsp_green_out;
   logic [CHAN_W-1:0]     rsp_red_out;
   logic                  rsp_marked;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    failures;
   int                    awaiting;

   bit                    calm = 1'b0;
   bit                    loaded [CELLS];
   int                    loaded_list [$];
   int                    seed_r, seed_c, used_r, used_c;

   color_region_grow_engine dut (.*);

   region_grow_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("color_region_grow_engine verification failed");
      $finish;
   end

   initial begin : result_side
      int stall;
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [PIX_W-1:0] pick_color();
      logic [PIX_W-1:0] palette [4];
      logic [PIX_W-1:0] pix;
      int ch;
      palette = '{24'h202020, 24'hE0E0E0, 24'h1080F0, 24'hF04010};
      if ($urandom_range(0, 4) == 0) return PIX_W'($urandom);
      pix = palette[$urandom_range(0, 3)];
      for (int k = 0; k < 3; k++) begin
         ch = int'(pix[8*k +: 8]) + $urandom_range(0, 30) - 15;
         pix[8*k +: 8] = (ch < 0) ? 8'd0 : (ch > 255) ? 8'd255 : ch[7:0];
      end
      return pix;
   endfunction

   task automatic issue(op_type op, int r, int c, logic [PIX_W-1:0] color);
      int gap;
      int a;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_row <= r[7:0];
      req_col <= c[7:0];
      req_blue_in <= color[7:0];
      req_green_in <= color[15:8];
      req_red_in <= color[23:16];
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      a = (r % 256) * MAX_COLS + (c % 256);
      if (op == OP_LOAD && !loaded[a]) begin
         loaded[a] = 1'b1;
         loaded_list = {loaded_list, a};
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(int sr, int sc, int thr, int nr, int nc);
      seed_r = sr;
      seed_c = sc;
      used_r = (nr > MAX_ROWS) ? MAX_ROWS : nr;
      used_c = (nc > MAX_COLS) ? MAX_COLS : nc;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SEED_ROW;
      csr_wdata <= CSR_DATA_W'(sr);
      @(posedge clock);
      csr_index <= CSR_SEED_COL;
      csr_wdata <= CSR_DATA_W'(sc);
      @(posedge clock);
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_index <= CSR_IMAGE_ROWS;
      csr_wdata <= CSR_DATA_W'(nr);
      @(posedge clock);
      csr_index <= CSR_IMAGE_COLS;
      csr_wdata <= CSR_DATA_W'(nc);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic grow_from(int r, int c);
      for (int y = 0; y < used_r; y++)
         for (int x = 0; x < used_c; x++)
            if (!loaded[y * MAX_COLS + x]) issue(OP_LOAD, y, x, pick_color());
      if (!loaded[seed_r * MAX_COLS + seed_c]) issue(OP_LOAD, seed_r, seed_c, pick_color());
      issue(OP_GROW, r, c, '0);
   endtask

   task automatic read_some();
      int r;
      int c;
      int a;
      r = (used_r > 0) ? $urandom_range(0, used_r - 1) : 0;
      c = (used_c > 0) ? $urandom_range(0, used_c - 1) : 0;
      a = r * MAX_COLS + c;
      if (used_r == 0 || used_c == 0 || !loaded[a] || $urandom_range(0, 9) < 3)
         a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      issue(OP_READ, a / MAX_COLS, a % MAX_COLS, '0);
   endtask

   initial begin : stimulus
      int p_rows [10] = '{256, 2, 0, 1, 511, 16, 12, 8, 16, 5};
      int p_cols [10] = '{256, 2, 5, 256, 1, 16, 9, 16, 16, 7};
      int p_thr  [10] = '{0, 511, 7, 20, 40, 30, 0, 100, 60, 511};
      int pick;
      int r;
      int c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(OP_LOAD, 0, 0, 24'h000000);
      issue(OP_LOAD, 255, 255, 24'hFFFFFF);
      issue(OP_LOAD, 0, 255, 24'hFF0000);
      issue(OP_LOAD, 255, 0, 24'h00FFFF);
      issue(OP_READ, 0, 0, '0);
      issue(OP_READ, 255, 255, '0);
      issue(OP_CLEAR, 0, 0, '0);

      for (int p = 0; p < 10; p++) begin
         settle();
         calm = (p == 3 || p == 7);
         if (p == 7)
            configure(200, 200, p_thr[p], p_rows[p], p_cols[p]);
         else if (p == 0)
            configure(255, 255, p_thr[p], p_rows[p], p_cols[p]);
         else
            configure($urandom_range(0, (p_rows[p] > 0 ? p_rows[p] : 1) - 1) % 256,
                      $urandom_range(0, (p_cols[p] > 0 ? p_cols[p] : 1) - 1) % 256,
                      p_thr[p], p_rows[p], p_cols[p]);
         if (p > 0) begin
            grow_from(used_r > 255 ? 255 : used_r, used_c > 255 ? 255 : used_c);
            grow_from(0, 0);
            issue(OP_READ, 0, 0, '0);
         end
         for (int i = 0; i < 70; i++) begin
            if (p % 2 == 1 && i == 35) issue(OP_CLEAR, $urandom, $urandom, '0);
            pick = $urandom_range(0, 19);
            if (pick >= 16 && used_r * used_c <= 256) begin
               r = $urandom_range(0, used_r > 255 ? 255 : used_r);
               c = $urandom_range(0, used_c > 255 ? 255 : used_c);
               grow_from(r, c);
            end else if (pick < 7 || loaded_list.size() == 0) begin
               if (used_r > 0 && used_c > 0 && $urandom_range(0, 3) != 0) begin
                  r = $urandom_range(0, used_r - 1);
                  c = $urandom_range(0, used_c - 1);
               end else begin
                  r = $urandom_range(0, 255);
                  c = $urandom_range(0, 255);
               end
               issue(OP_LOAD, r, c, pick_color());
            end else begin
               read_some();
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("color_region_grow_engine verification clean");
      else
         $display("color_region_grow_engine verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/crge_pkg.sv
design/crge_ram.sv
design/crge_ctrl.sv
design/crge_datapath.sv
design/color_region_grow_engine.sv
test/region_grow_checker.sv
test/testbench.sv
